### rtl/mcr_pkg.sv
// Shared types, register map and constants for the monotonic millisecond clock.
package mcr_pkg;

  // Sample word: raw time from the source
  typedef struct packed {
    logic [31:0] raw_seconds;
    logic [9:0]  raw_millis;
  } sample_t;

  // Result word: monotonic time and event counters
  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] glitch_total;
    logic [31:0] resync_total;
  } result_t;

  // Live configuration handed from the register block to the core
  typedef struct packed {
    logic [15:0] offset_limit_ms;
    logic [15:0] hold_ms;
    logic [15:0] jitter_limit_ms;
  } cfg_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_OFFSET_LIMIT = 2'd0;
  localparam logic [1:0] REG_HOLD         = 2'd1;
  localparam logic [1:0] REG_JITTER_LIMIT = 2'd2;

  localparam int unsigned PADDR_W = 4;

  // Reset values of the registers
  localparam logic [15:0] OFFSET_LIMIT_RST = 16'd700;
  localparam logic [15:0] HOLD_RST         = 16'd1500;
  localparam logic [15:0] JITTER_LIMIT_RST = 16'd50;

  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  // Two's complement magnitude of a 64-bit value
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

### rtl/mcr_regs.sv
// APB-style configuration registers for the millisecond clock.
module mcr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mcr_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes; byte offset within the word is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_limit_ms <= mcr_pkg::OFFSET_LIMIT_RST;
      cfg.hold_ms         <= mcr_pkg::HOLD_RST;
      cfg.jitter_limit_ms <= mcr_pkg::JITTER_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mcr_pkg::REG_OFFSET_LIMIT: cfg.offset_limit_ms <= pwdata[15:0];
        mcr_pkg::REG_HOLD:         cfg.hold_ms         <= pwdata[15:0];
        mcr_pkg::REG_JITTER_LIMIT: cfg.jitter_limit_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux; unmapped addresses read zero
  always_comb begin
    case (reg_idx)
      mcr_pkg::REG_OFFSET_LIMIT: prdata = {16'd0, cfg.offset_limit_ms};
      mcr_pkg::REG_HOLD:         prdata = {16'd0, cfg.hold_ms};
      mcr_pkg::REG_JITTER_LIMIT: prdata = {16'd0, cfg.jitter_limit_ms};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

### rtl/mcr_core.sv
// Clock state and the combinational update that produces one result per sample.
module mcr_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [63:0]          raw_now,
  input  logic [9:0]           raw_millis,
  input  mcr_pkg::cfg_t        cfg,
  output mcr_pkg::result_t     result
);

  // State
  logic        started;
  logic [31:0] count_ms;
  logic [9:0]  previous_millis;
  logic [63:0] raw_base_ms;
  logic [31:0] glitch_count;
  logic [31:0] resync_count;
  logic        offset_active;
  logic [31:0] offset_start_ms;
  logic [63:0] last_offset;

  logic        started_next;
  logic [31:0] count_ms_next;
  logic [63:0] raw_base_ms_next;
  logic [31:0] glitch_count_next;
  logic [31:0] resync_count_next;
  logic        offset_active_next;
  logic        offset_start_load;
  logic [63:0] last_offset_next;

  logic [11:0] step_raw;
  logic [9:0]  step;
  logic [31:0] count_inc;
  logic [63:0] elapsed;
  logic [63:0] offset;
  logic [63:0] jitter;
  logic        over_limit;
  logic        hold_ok;
  logic        jitter_ok;
  logic [31:0] held_ms;

  // Millisecond step modulo 1000; sum lies in 977..3023
  always_comb begin
    step_raw = 12'd2000 + {2'd0, raw_millis} - {2'd0, previous_millis};
    if (step_raw >= 12'd3000) begin
      step = 10'(step_raw - 12'd3000);
    end else if (step_raw >= 12'd2000) begin
      step = 10'(step_raw - 12'd2000);
    end else if (step_raw >= 12'd1000) begin
      step = 10'(step_raw - 12'd1000);
    end else begin
      step = step_raw[9:0];
    end
  end

  // Offset tests against the raw elapsed time
  assign count_inc  = count_ms + {22'd0, step};
  assign elapsed    = raw_now - raw_base_ms;
  assign offset     = elapsed - {32'd0, count_inc};
  assign jitter     = mcr_pkg::mag64(offset - last_offset);
  assign over_limit = mcr_pkg::mag64(offset) > {48'd0, cfg.offset_limit_ms};
  assign held_ms    = count_inc - offset_start_ms;
  assign hold_ok    = held_ms > {16'd0, cfg.hold_ms};
  assign jitter_ok  = jitter < {48'd0, cfg.jitter_limit_ms};

  // Next state
  always_comb begin
    started_next       = 1'b1;
    count_ms_next      = count_inc;
    raw_base_ms_next   = raw_base_ms;
    glitch_count_next  = glitch_count;
    resync_count_next  = resync_count;
    offset_active_next = offset_active;
    offset_start_load  = 1'b0;
    last_offset_next   = offset;
    if (!started) begin
      // first sample only sets the base
      count_ms_next      = 32'd0;
      raw_base_ms_next   = raw_now;
      glitch_count_next  = 32'd0;
      resync_count_next  = 32'd0;
      offset_active_next = 1'b0;
      last_offset_next   = 64'd0;
    end else if (over_limit) begin
      if (!offset_active) begin
        offset_active_next = 1'b1;
        offset_start_load  = 1'b1;
        glitch_count_next  = glitch_count + 32'd1;
      end else if (hold_ok && jitter_ok) begin
        // forward: jump count; backward: move the raw base
        if (!offset[63]) begin
          count_ms_next = elapsed[31:0];
        end else begin
          raw_base_ms_next = raw_now - {32'd0, count_inc};
        end
        offset_active_next = 1'b0;
        resync_count_next  = resync_count + 32'd1;
      end
    end else begin
      offset_active_next = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      count_ms      <= 32'd0;
      previous_millis <= 10'd0;
      raw_base_ms   <= 64'd0;
      glitch_count  <= 32'd0;
      resync_count  <= 32'd0;
      offset_active <= 1'b0;
      last_offset   <= 64'd0;
    end else if (fire) begin
      started       <= started_next;
      count_ms      <= count_ms_next;
      previous_millis <= raw_millis;
      raw_base_ms   <= raw_base_ms_next;
      glitch_count  <= glitch_count_next;
      resync_count  <= resync_count_next;
      offset_active <= offset_active_next;
      last_offset   <= last_offset_next;
    end
  end

  // Onset time; only read while an offset is active
  always_ff @(posedge clk) begin
    if (fire && offset_start_load) begin
      offset_start_ms <= count_inc;
    end
  end

  assign result.now_ms       = count_ms_next;
  assign result.glitch_total = glitch_count_next;
  assign result.resync_total = resync_count_next;

endmodule

### rtl/monotonic_ms_clock_resync.sv
// Monotonic millisecond clock with resync to a raw time source: top level.
//
// Usage:
//   sample channel: sample_valid/sample_ready carry one raw time word
//   (seconds, milliseconds). result channel: result_valid/result_ready carry
//   one word per sample (monotonic ms, glitch count, resync count).
//   APB port: offset limit at 0x0, hold time at 0x4, jitter limit at 0x8;
//   write only while no sample is in flight.
// Pipeline: input register holding the seconds*1000 product, then the state
//   update into the result register; result_valid rises when the result
//   register loads, which waits while the result word is not taken.
// Throughput: one sample per cycle while result_ready is high; each
//   sample's state update lies between the input and result registers.
// Reset: clears the clock state and loads the register defaults; the first
//   sample after reset sets the raw base and reports all zeros.
// Stall: while result_ready is low the result word holds; the input register
//   still takes one more sample, then sample_ready drops until the result
//   word is taken.
module monotonic_ms_clock_resync (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  mcr_pkg::sample_t            sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output mcr_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  mcr_pkg::cfg_t    cfg;
  mcr_pkg::result_t core_result;

  logic        s1_valid;
  logic [63:0] s1_raw_now;
  logic [9:0]  s1_millis;
  logic        advance;
  logic        accept;
  logic [41:0] raw_now_in;

  mcr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input stage moves on when the result register is free
  assign advance      = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || advance;
  assign accept       = sample_valid && sample_ready;

  // Raw time in ms of the incoming word
  assign raw_now_in = {10'd0, sample.raw_seconds} * {32'd0, mcr_pkg::MS_PER_SEC} +
                      {32'd0, sample.raw_millis};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_raw_now <= {22'd0, raw_now_in};
      s1_millis  <= sample.raw_millis;
    end
  end

  mcr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .raw_now    (s1_raw_now),
    .raw_millis (s1_millis),
    .cfg        (cfg),
    .result     (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

endmodule
